@@ hdl/fsdd_pkg.sv @@
// ----------------------------------------------------------------------------
// fsdd_pkg
// Shared widths, constants and types of the stereo downmix decimator.
// ----------------------------------------------------------------------------
package fsdd_pkg;

   // samples per output beat: three stereo frames
   localparam int GROUP_SIZE = 6;

   localparam int WORD_W  = 32;
   localparam int PCM_W   = 16;
   localparam int PHASE_W = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;
   localparam int SUM_W   = PCM_W + $clog2(GROUP_SIZE);

   // divide by GROUP_SIZE: exact multiply by ceil(2^DIV_SHIFT / GROUP_SIZE)
   localparam int DIV_SHIFT = SUM_W + $clog2(GROUP_SIZE);
   localparam int RECIP_W   = SUM_W + 1;
   localparam int PROD_W    = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] DIV_RECIP =
      RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(GROUP_SIZE) - 64'd1) / 64'(GROUP_SIZE));

   // binary32 exponent codes
   localparam logic [7:0] EXP_SPECIAL = 8'hFF;
   localparam logic [7:0] EXP_DENORM  = 8'h00;
   localparam logic [7:0] EXP_SAT     = 8'd135;  // |x| * 2^15 >= 2^23
   localparam logic [7:0] EXP_TINY    = 8'd112;  // below this |x| * 2^15 < 1

   typedef logic signed [PCM_W-1:0] pcm_type;
   typedef logic signed [SUM_W-1:0] sum_type;

   localparam pcm_type PCM_MAX = pcm_type'(16'sh7FFF);
   localparam pcm_type PCM_MIN = pcm_type'(16'sh8000);

endpackage

@@ hdl/fsdd_ifs.sv @@
// ----------------------------------------------------------------------------
// fsdd channel interfaces
// Valid/ready channels for float sample beats in and PCM beats out.
// ----------------------------------------------------------------------------
interface fsdd_req_if;
   logic                         valid;
   logic                         ready;
   logic [fsdd_pkg::WORD_W-1:0]  sample_word;
   logic                         silent;
   logic                         packet_end;

   modport source (output valid, output sample_word, output silent,
                   output packet_end, input ready);
   modport sink   (input valid, input sample_word, input silent,
                   input packet_end, output ready);
endinterface

interface fsdd_rsp_if;
   logic                 valid;
   logic                 ready;
   fsdd_pkg::pcm_type    mono_sample;

   modport source (output valid, output mono_sample, input ready);
   modport sink   (input valid, input mono_sample, output ready);
endinterface

@@ hdl/float_stereo_downmix_decimator_core.sv @@
// ----------------------------------------------------------------------------
// float_stereo_downmix_decimator_core
// Interleaved binary32 stereo in, averaged 16-bit mono PCM out at 1/6 rate.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one channel sample per beat (L, R, L, R ...) as a
//   binary32 bit pattern. silent forces the sample to 0.0; packet_end on a
//   beat drops a group that is still incomplete after that beat.
//   Each sample becomes floor(x * 32768), saturated to 16 bits, NaN -> 0.
//   Every GROUP_SIZE samples one rsp_chan beat carries their sum divided
//   by GROUP_SIZE, truncated toward zero.
// Timing:
//   One beat per cycle sustained while rsp_chan is not stalled. Three register
//   stages: input register, convert/accumulate with a finished group into the
//   sum register, divide into the output register. The last sample of a group
//   passes the input, sum and output registers before it shows on rsp_chan.
// Reset (synchronous): all stages empty, group phase and sum cleared.
// Stall: while rsp_chan.ready is low the output holds; the pipeline keeps
//   taking beats until a finished group would have to enter a full stage,
//   then req_chan.ready drops.
// ----------------------------------------------------------------------------
module float_stereo_downmix_decimator_core (
   input  logic          clock,
   input  logic          reset,
   fsdd_req_if.sink      req_chan,
   fsdd_rsp_if.source    rsp_chan
);
   import fsdd_pkg::*;

   // input register
   logic                in_vld_ff, in_vld_in;
   logic [WORD_W-1:0]   in_word_ff;
   logic                in_silent_ff;
   logic                in_pend_ff;

   // group state
   logic [PHASE_W-1:0]  phase_ff, phase_in;
   sum_type             acc_ff, acc_in;

   // finished group sum
   logic                sum_vld_ff, sum_vld_in;
   sum_type             sum_ff, sum_in;

   // output register
   logic                rsp_vld_ff, rsp_vld_in;
   pcm_type             rsp_data_ff, rsp_data_in;

   logic                rsp_adv, sum_adv, s0_go, emit;
   pcm_type             conv;
   sum_type             acc_next;

   // float to Q15 floor conversion
   logic                f_neg;
   logic [7:0]          f_exp;
   logic [22:0]         f_man;
   logic [23:0]         f_sig, f_ip;
   logic [4:0]          f_sh;
   logic                f_frac_nz;
   logic [24:0]         f_ipn;

   always_comb begin
      f_neg     = in_word_ff[31];
      f_exp     = in_word_ff[30:23];
      f_man     = in_word_ff[22:0];
      f_sig     = {1'b1, f_man};
      f_sh      = 5'(EXP_SAT - f_exp);
      f_ip      = f_sig >> f_sh;
      f_frac_nz = |(f_sig & ~(24'hFFFFFF << f_sh));
      f_ipn     = {1'b0, f_ip} + 25'(f_frac_nz);
      priority if (in_silent_ff) begin
         conv = '0;
      end else if (f_exp == EXP_SPECIAL) begin
         conv = (f_man != '0) ? pcm_type'(0) : (f_neg ? PCM_MIN : PCM_MAX);
      end else if (f_exp == EXP_DENORM) begin
         conv = (f_man == '0 || !f_neg) ? pcm_type'(0) : pcm_type'(-1);
      end else if (f_exp >= EXP_SAT) begin
         conv = f_neg ? PCM_MIN : PCM_MAX;
      end else if (f_exp < EXP_TINY) begin
         conv = f_neg ? pcm_type'(-1) : pcm_type'(0);
      end else if (!f_neg) begin
         conv = (f_ip > 24'd32767) ? PCM_MAX : pcm_type'(f_ip[PCM_W-1:0]);
      end else begin
         conv = (f_ipn >= 25'd32768) ? PCM_MIN
                                     : pcm_type'(~f_ipn[PCM_W-1:0] + 16'd1);
      end
   end

   // stage handshakes
   assign rsp_adv = !rsp_vld_ff || rsp_chan.ready;
   assign sum_adv = !sum_vld_ff || rsp_adv;
   assign emit    = (phase_ff == PHASE_W'(GROUP_SIZE - 1));
   assign s0_go   = in_vld_ff && (!emit || sum_adv);

   assign req_chan.ready = !in_vld_ff || s0_go;

   assign acc_next = acc_ff + sum_type'(conv);

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_chan.ready) begin
         in_vld_in = req_chan.valid;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      if (s0_go) begin
         if (emit || in_pend_ff) begin
            phase_in = '0;
            acc_in   = '0;
         end else begin
            phase_in = phase_ff + PHASE_W'(1);
            acc_in   = acc_next;
         end
      end
   end

   always_comb begin
      sum_vld_in = sum_vld_ff;
      sum_in     = sum_ff;
      if (sum_adv) begin
         sum_vld_in = s0_go && emit;
         sum_in     = acc_next;
      end
   end

   // divide stage: |sum| * reciprocal, then restore the sign
   logic                sum_neg;
   logic [SUM_W-1:0]    sum_mag;
   logic [PROD_W-1:0]   div_prod;
   logic [PCM_W-1:0]    div_quo;

   always_comb begin
      sum_neg  = sum_ff[SUM_W-1];
      sum_mag  = sum_neg ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
      div_prod = PROD_W'(sum_mag) * PROD_W'(DIV_RECIP);
      div_quo  = div_prod[DIV_SHIFT +: PCM_W];
      rsp_vld_in  = rsp_vld_ff;
      rsp_data_in = rsp_data_ff;
      if (rsp_adv) begin
         rsp_vld_in  = sum_vld_ff;
         rsp_data_in = sum_neg ? pcm_type'(~div_quo + 16'd1) : pcm_type'(div_quo);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         phase_ff   <= '0;
         acc_ff     <= '0;
         sum_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         phase_ff   <= phase_in;
         acc_ff     <= acc_in;
         sum_vld_ff <= sum_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready) begin
         in_word_ff   <= req_chan.sample_word;
         in_silent_ff <= req_chan.silent;
         in_pend_ff   <= req_chan.packet_end;
      end
      sum_ff      <= sum_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid       = rsp_vld_ff;
   assign rsp_chan.mono_sample = rsp_data_ff;

   // checks
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PHASE_W'(GROUP_SIZE - 1))
      else $error("group phase out of range");

   a_pend_clears: assert property (@(posedge clock) disable iff (reset)
      s0_go && in_pend_ff |=> phase_ff == '0 && acc_ff == '0)
      else $error("packet end did not restart the group");

   a_sum_to_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_adv && sum_vld_ff |=> rsp_vld_ff)
      else $error("finished group lost before output register");

   a_quo_range: assert property (@(posedge clock) disable iff (reset)
      sum_vld_ff |-> div_prod[PROD_W-1:DIV_SHIFT] <= (PROD_W - DIV_SHIFT)'(32768))
      else $error("quotient exceeds 16-bit range");

endmodule
